[rtl/core/chdc_pkg.sv]
// shared types and constants of the hot/dead channel classifier
`timescale 1ns / 1ps

package chdc_pkg;

  // fixed field widths
  localparam int CH_W    = 12;
  localparam int ADC_W   = 8;
  localparam int SUM_W   = 32;
  localparam int SQ_W    = 40;
  localparam int CFG_W   = 8;

  // apb port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // status arithmetic: 40x20 multiplier, second operand taken as two 20-bit digits
  localparam int MUL_W     = 40;
  localparam int DIG_W     = 20;
  localparam int PROD_W    = MUL_W + DIG_W;
  localparam int ACC_W     = 82;
  localparam int MUL_STEPS = 6;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [1:0] REG_SHIFT = 2'd0;
  localparam logic [1:0] REG_DEAD  = 2'd1;
  localparam logic [1:0] REG_HOT   = 2'd2;
  localparam logic [1:0] REG_RMS   = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] SHIFT_RST = 8'd0;
  localparam logic [CFG_W-1:0] DEAD_RST  = 8'd10;
  localparam logic [CFG_W-1:0] HOT_RST   = 8'd180;
  localparam logic [CFG_W-1:0] RMS_RST   = 8'd100;

  // status codes
  localparam logic [1:0] STATUS_GOOD  = 2'd0;
  localparam logic [1:0] STATUS_DEAD  = 2'd1;
  localparam logic [1:0] STATUS_HOT   = 2'd2;
  localparam logic [1:0] STATUS_NOISY = 2'd3;

  // commands
  localparam logic CMD_HIT    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // threshold codes on which a hit is dropped
  localparam logic [ADC_W-1:0] TH_OFF_LO = 8'd0;
  localparam logic [ADC_W-1:0] TH_OFF_HI = 8'd255;

  typedef struct packed {
    logic [CFG_W-1:0] th_offset;
    logic [CFG_W-1:0] dead_mean_limit;
    logic [CFG_W-1:0] hot_mean_limit;
    logic [CFG_W-1:0] rms_limit;
  } cfg_t;

  typedef struct packed {
    logic             command;
    logic             in_range;
    logic [CH_W-1:0]  channel;
    logic [ADC_W-1:0] adc;
  } op_t;

endpackage

[rtl/core/chdc_in_if.sv]
// input request channel of the classifier
`timescale 1ns / 1ps

interface chdc_in_if;
  import chdc_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [CH_W-1:0]  channel;
  logic [ADC_W-1:0] adc;
  logic [ADC_W-1:0] threshold;

  modport source (output valid, command, channel, adc, threshold, input ready);
  modport sink (input valid, command, channel, adc, threshold, output ready);
endinterface

[rtl/core/chdc_out_if.sv]
// result channel of the classifier
`timescale 1ns / 1ps

interface chdc_out_if #(
  parameter int COUNT_BITS = 24
);
  import chdc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       out_channel;
  logic [COUNT_BITS-1:0] hit_total;
  logic [SUM_W-1:0]      adc_sum;
  logic [SQ_W-1:0]       adc_square_sum;
  logic [1:0]            status;

  modport source (output valid, out_channel, hit_total, adc_sum, adc_square_sum, status,
                  input ready);
  modport sink (input valid, out_channel, hit_total, adc_sum, adc_square_sum, status,
                output ready);
endinterface

[rtl/core/channel_hot_dead_classifier_unit.sv]
// hot/dead channel classifier, top level
// report path: store read, status unit, then the result output register
// hits: the back end reads the store entry, then writes it back;
//   a report also waits for the status unit, which may run the variance test on the 40x20 multiplier
// reset: synchronous, active low; then a clearing pass over all NUM_CHANNELS store entries
`timescale 1ns / 1ps

module channel_hot_dead_classifier_unit #(
  parameter int NUM_CHANNELS = 4096,
  parameter int COUNT_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  chdc_in_if.sink                      in_req,
  chdc_out_if.source                   out_req,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chdc_pkg::PADDR_W-1:0] paddr,
  input  logic [chdc_pkg::PDATA_W-1:0] pwdata,
  output logic [chdc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import chdc_pkg::*;

  // configuration registers
  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // front to queue
  logic fifo_push, fifo_pop, fifo_empty, fifo_full;
  op_t  push_op, head_op;

  // back to status unit
  logic                  clearing;
  logic                  cls_start, cls_done;
  logic [1:0]            cls_status;
  logic [COUNT_BITS-1:0] rep_cnt;
  logic [SUM_W-1:0]      rep_sum;
  logic [SQ_W-1:0]       rep_sq;

  // apb: write on the access cycle, no wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SHIFT: cfg_nxt.th_offset       = pwdata[CFG_W-1:0];
        REG_DEAD:  cfg_nxt.dead_mean_limit = pwdata[CFG_W-1:0];
        REG_HOT:   cfg_nxt.hot_mean_limit  = pwdata[CFG_W-1:0];
        REG_RMS:   cfg_nxt.rms_limit       = pwdata[CFG_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.th_offset       <= SHIFT_RST;
      cfg_r.dead_mean_limit <= DEAD_RST;
      cfg_r.hot_mean_limit  <= HOT_RST;
      cfg_r.rms_limit       <= RMS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // register readback, zero extended
  always_comb begin
    case (cfg_idx)
      REG_SHIFT: prdata = PDATA_W'(cfg_r.th_offset);
      REG_DEAD:  prdata = PDATA_W'(cfg_r.dead_mean_limit);
      REG_HOT:   prdata = PDATA_W'(cfg_r.hot_mean_limit);
      REG_RMS:   prdata = PDATA_W'(cfg_r.rms_limit);
      default:   prdata = '0;
    endcase
  end

  // front: filters hits by threshold and channel range, queues the rest
  chdc_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_req    (in_req),
    .cfg       (cfg_r),
    .clearing  (clearing),
    .fifo_full (fifo_full),
    .push      (fifo_push),
    .push_op   (push_op)
  );

  // lets the front keep taking requests while a report is being classified
  chdc_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fifo_push),
    .push_op (push_op),
    .pop     (fifo_pop),
    .head_op (head_op),
    .empty   (fifo_empty),
    .full    (fifo_full)
  );

  // back: one request at a time against the channel store
  chdc_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_op    (head_op),
    .fifo_empty (fifo_empty),
    .pop        (fifo_pop),
    .clearing   (clearing),
    .cls_start  (cls_start),
    .rep_cnt    (rep_cnt),
    .rep_sum    (rep_sum),
    .rep_sq     (rep_sq),
    .cls_done   (cls_done),
    .cls_status (cls_status),
    .out_req    (out_req)
  );

  // status unit: mean limits first, then count*sqsum - sum^2 against (rms*count)^2
  chdc_classify #(
    .COUNT_BITS (COUNT_BITS)
  ) u_classify (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .start  (cls_start),
    .cnt    (rep_cnt),
    .sum    (rep_sum),
    .sq     (rep_sq),
    .done   (cls_done),
    .status (cls_status)
  );

  // no result can be pending while the store is still being cleared
  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_req.valid)
    else $error("result valid during clearing pass");

  // an empty channel always reports dead
  a_empty_is_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_req.valid && (out_req.hit_total == '0)) |-> (out_req.status == STATUS_DEAD))
    else $error("empty channel not reported dead");

  // hot needs a nonzero sum
  a_hot_has_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_req.valid && (out_req.status == STATUS_HOT)) |-> (out_req.adc_sum != '0))
    else $error("hot status with zero sum");

  // the back end never pops an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("queue popped while empty");
endmodule

[rtl/core/chdc_ram.sv]
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps

module chdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[rtl/core/chdc_fifo.sv]
// short request queue between front and back
`timescale 1ns / 1ps

module chdc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  chdc_pkg::op_t  push_op,
  input  logic           pop,
  output chdc_pkg::op_t  head_op,
  output logic           empty,
  output logic           full
);
  import chdc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_op = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_op;
    end
  end
endmodule

[rtl/core/chdc_front.sv]
// front end: takes requests, drops ignored hits, queues the rest
`timescale 1ns / 1ps

module chdc_front #(
  parameter int NUM_CHANNELS = 4096
) (
  chdc_in_if.sink        in_req,
  input  chdc_pkg::cfg_t cfg,
  input  logic           clearing,
  input  logic           fifo_full,
  output logic           push,
  output chdc_pkg::op_t  push_op
);
  import chdc_pkg::*;

  logic           in_range;
  logic           th_on;
  logic           above;
  logic           keep;
  logic [ADC_W:0] adc_sh;

  assign in_range = (32'(in_req.channel) < 32'(NUM_CHANNELS));
  assign th_on    = (in_req.threshold != TH_OFF_LO) && (in_req.threshold != TH_OFF_HI);
  // adc > threshold - shift, done without going negative
  assign adc_sh   = {1'b0, in_req.adc} + {1'b0, cfg.th_offset};
  assign above    = (adc_sh > {1'b0, in_req.threshold});
  assign keep     = (in_req.command == CMD_REPORT) || (in_range && th_on && above);

  assign in_req.ready = !fifo_full && !clearing;
  assign push         = in_req.valid && in_req.ready && keep;

  always_comb begin
    push_op.command  = in_req.command;
    push_op.in_range = in_range;
    push_op.channel  = in_req.channel;
    push_op.adc      = in_req.adc;
  end
endmodule

[rtl/core/chdc_classify.sv]
// status unit: dead/hot compare, then variance test on a shared 40x20 multiplier
`timescale 1ns / 1ps

module chdc_classify #(
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chdc_pkg::cfg_t                cfg,
  input  logic                          start,
  input  logic [COUNT_BITS-1:0]         cnt,
  input  logic [chdc_pkg::SUM_W-1:0]    sum,
  input  logic [chdc_pkg::SQ_W-1:0]     sq,
  output logic                          done,
  output logic [1:0]                    status
);
  import chdc_pkg::*;

  localparam int LP_W = COUNT_BITS + CFG_W;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_MUL  = 3'b010,
    C_FIN  = 3'b100
  } cstate_t;

  cstate_t           state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [MUL_W-1:0]  lc_r, lc_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              neg_r, neg_nxt;
  logic              hi_r, hi_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  logic [LP_W-1:0]   dead_prod, hot_prod, lc_full;
  logic              is_dead, is_hot;
  logic [MUL_W-1:0]  x_op, y_op;
  logic [DIG_W-1:0]  digit;
  logic [ACC_W-1:0]  term;

  assign dead_prod = LP_W'(cfg.dead_mean_limit) * LP_W'(cnt);
  assign hot_prod  = LP_W'(cfg.hot_mean_limit) * LP_W'(cnt);
  assign lc_full   = LP_W'(cfg.rms_limit) * LP_W'(cnt);
  assign is_dead   = (cnt == '0) || (MUL_W'(sum) < MUL_W'(dead_prod));
  assign is_hot    = (MUL_W'(sum) > MUL_W'(hot_prod));

  // step pairs: cnt*sq added, sum*sum and lc*lc subtracted
  always_comb begin
    case (step_r[2:1])
      2'd0: begin
        x_op = sq;
        y_op = MUL_W'(cnt);
      end
      2'd1: begin
        x_op = MUL_W'(sum);
        y_op = MUL_W'(sum);
      end
      default: begin
        x_op = lc_r;
        y_op = lc_r;
      end
    endcase
  end

  assign digit = step_r[0] ? y_op[MUL_W-1:DIG_W] : y_op[DIG_W-1:0];
  assign term  = hi_r ? (ACC_W'(prod_r) << DIG_W) : ACC_W'(prod_r);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    done_nxt   = 1'b0;
    status_nxt = status_r;
    lc_nxt     = lc_r;
    prod_nxt   = prod_r;
    neg_nxt    = neg_r;
    hi_nxt     = hi_r;
    acc_nxt    = acc_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          if (is_dead) begin
            status_nxt = STATUS_DEAD;
            done_nxt   = 1'b1;
          end else if (is_hot) begin
            status_nxt = STATUS_HOT;
            done_nxt   = 1'b1;
          end else begin
            lc_nxt    = MUL_W'(lc_full);
            acc_nxt   = '0;
            step_nxt  = '0;
            state_nxt = C_MUL;
          end
        end
      end
      C_MUL: begin
        if (step_r < 3'(MUL_STEPS)) begin
          prod_nxt = x_op * digit;
          neg_nxt  = (step_r[2:1] != 2'd0);
          hi_nxt   = step_r[0];
        end
        // accumulate the product of the previous step
        if (step_r != '0) begin
          acc_nxt = neg_r ? acc_r - term : acc_r + term;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 3'(MUL_STEPS)) begin
          state_nxt = C_FIN;
        end
      end
      C_FIN: begin
        status_nxt = (!acc_r[ACC_W-1] && (acc_r != '0)) ? STATUS_NOISY : STATUS_GOOD;
        done_nxt   = 1'b1;
        state_nxt  = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    lc_r     <= lc_nxt;
    prod_r   <= prod_nxt;
    neg_r    <= neg_nxt;
    hi_r     <= hi_nxt;
    acc_r    <= acc_nxt;
  end

  assign done   = done_r;
  assign status = status_r;
endmodule

[rtl/core/chdc_back.sv]
// back end: clearing pass, read-modify-write of channel sums, report output register
`timescale 1ns / 1ps

module chdc_back #(
  parameter int NUM_CHANNELS = 4096,
  parameter int COUNT_BITS   = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  chdc_pkg::op_t              head_op,
  input  logic                       fifo_empty,
  output logic                       pop,
  output logic                       clearing,
  output logic                       cls_start,
  output logic [COUNT_BITS-1:0]      rep_cnt,
  output logic [chdc_pkg::SUM_W-1:0] rep_sum,
  output logic [chdc_pkg::SQ_W-1:0]  rep_sq,
  input  logic                       cls_done,
  input  logic [1:0]                 cls_status,
  chdc_out_if.source                 out_req
);
  import chdc_pkg::*;

  localparam int AW    = $clog2(NUM_CHANNELS);
  localparam int ENT_W = COUNT_BITS + SUM_W + SQ_W;

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_EXEC  = 5'b00100,
    B_CLASS = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  bstate_t               state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  cls_start_r, cls_start_nxt;
  logic                  out_valid_r, out_valid_nxt;
  op_t                   op_r;
  logic [COUNT_BITS-1:0] rep_cnt_r;
  logic [SUM_W-1:0]      rep_sum_r;
  logic [SQ_W-1:0]       rep_sq_r;
  logic [CH_W-1:0]       out_channel_r;
  logic [COUNT_BITS-1:0] hit_total_r;
  logic [SUM_W-1:0]      adc_sum_r;
  logic [SQ_W-1:0]       adc_square_sum_r;
  logic [1:0]            status_r;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ENT_W-1:0]      ram_wdata, ram_rdata;
  logic [AW+CH_W-1:0]    head_ext, op_ext;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic [SUM_W-1:0]      rd_sum;
  logic [SQ_W-1:0]       rd_sq;
  logic [2*ADC_W-1:0]    adc_sq;
  logic [SUM_W:0]        sum_new;
  logic [SQ_W:0]         sq_new;
  logic                  saturated;
  logic                  rep_load, out_load;

  chdc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign head_ext  = (AW+CH_W)'(head_op.channel);
  assign op_ext    = (AW+CH_W)'(op_r.channel);
  assign ram_raddr = head_ext[AW-1:0];

  assign rd_cnt = ram_rdata[ENT_W-1 -: COUNT_BITS];
  assign rd_sum = ram_rdata[SQ_W +: SUM_W];
  assign rd_sq  = ram_rdata[SQ_W-1:0];

  // a hit that would overflow any field is dropped and leaves the channel entry unchanged
  assign adc_sq    = op_r.adc * op_r.adc;
  assign sum_new   = {1'b0, rd_sum} + (SUM_W+1)'(op_r.adc);
  assign sq_new    = {1'b0, rd_sq} + (SQ_W+1)'(adc_sq);
  assign saturated = (&rd_cnt) || sum_new[SUM_W] || sq_new[SQ_W];

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cls_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && !out_req.ready;
    pop           = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = op_ext[AW-1:0];
    ram_wdata     = {rd_cnt + 1'b1, sum_new[SUM_W-1:0], sq_new[SQ_W-1:0]};
    rep_load      = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      B_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(NUM_CHANNELS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!fifo_empty) begin
          pop       = 1'b1;
          ram_re    = 1'b1;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (op_r.command == CMD_HIT) begin
          ram_we    = !saturated;
          state_nxt = B_IDLE;
        end else begin
          rep_load      = 1'b1;
          cls_start_nxt = 1'b1;
          state_nxt     = B_CLASS;
        end
      end
      B_CLASS: begin
        if (cls_done) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_req.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      cls_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cls_start_r <= cls_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r <= head_op;
    end
    if (rep_load) begin
      rep_cnt_r <= op_r.in_range ? rd_cnt : '0;
      rep_sum_r <= op_r.in_range ? rd_sum : '0;
      rep_sq_r  <= op_r.in_range ? rd_sq : '0;
    end
    if (out_load) begin
      out_channel_r    <= op_r.channel;
      hit_total_r      <= rep_cnt_r;
      adc_sum_r        <= rep_sum_r;
      adc_square_sum_r <= rep_sq_r;
      status_r         <= cls_status;
    end
  end

  assign clearing  = (state_r == B_CLEAR);
  assign cls_start = cls_start_r;
  assign rep_cnt   = rep_cnt_r;
  assign rep_sum   = rep_sum_r;
  assign rep_sq    = rep_sq_r;

  assign out_req.valid          = out_valid_r;
  assign out_req.out_channel    = out_channel_r;
  assign out_req.hit_total      = hit_total_r;
  assign out_req.adc_sum        = adc_sum_r;
  assign out_req.adc_square_sum = adc_square_sum_r;
  assign out_req.status         = status_r;
endmodule

[verif/tb.sv]
// self-checking testbench for the hot/dead channel classifier
`timescale 1ns / 1ps

module tb;
  import chdc_pkg::*;

  localparam int NUM_CH      = 4096;
  localparam int CNT_BITS    = 24;
  // the clearing pass after reset alone covers all NUM_CH channels
  localparam int IDLE_LIMIT  = 20000;
  // drain gap: time for a trailing hit write-back after the last report
  localparam int DRAIN_GAP   = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 295;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [CNT_BITS-1:0] total;
    logic [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]     square;
    logic [1:0]          status;
  } report_t;

  // per-channel accumulator model plus the queue of reports still owed
  class channel_stats_board;
    logic [CNT_BITS-1:0] hit_count [NUM_CH];
    logic [SUM_W-1:0]    adc_total [NUM_CH];
    logic [SQ_W-1:0]     square_total [NUM_CH];
    logic [CFG_W-1:0]    shift, dead_lim, hot_lim, rms_lim;
    report_t             pending_reports [$];
    int                  errors;

    function new();
      foreach (hit_count[i]) begin
        hit_count[i]    = '0;
        adc_total[i]    = '0;
        square_total[i] = '0;
      end
      shift    = SHIFT_RST;
      dead_lim = DEAD_RST;
      hot_lim  = HOT_RST;
      rms_lim  = RMS_RST;
      errors   = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_SHIFT: shift    = value;
        REG_DEAD:  dead_lim = value;
        REG_HOT:   hot_lim  = value;
        REG_RMS:   rms_lim  = value;
        default: ;
      endcase
    endfunction

    function logic [CFG_W-1:0] register_value(logic [1:0] idx);
      case (idx)
        REG_SHIFT: return shift;
        REG_DEAD:  return dead_lim;
        REG_HOT:   return hot_lim;
        default:   return rms_lim;
      endcase
    endfunction

    // mean and rms tests done as exact integer comparisons
    function logic [1:0] grade_channel(logic [CNT_BITS-1:0] c, logic [SUM_W-1:0] s,
                                       logic [SQ_W-1:0] q);
      logic [127:0] rms_scaled, spread_lhs, spread_rhs;
      if (c == 0) return STATUS_DEAD;
      if (64'(s) < 64'(dead_lim) * 64'(c)) return STATUS_DEAD;
      if (64'(s) > 64'(hot_lim) * 64'(c)) return STATUS_HOT;
      rms_scaled = 128'(rms_lim) * 128'(c);
      spread_lhs = 128'(c) * 128'(q);
      spread_rhs = 128'(s) * 128'(s) + rms_scaled * rms_scaled;
      return (spread_lhs > spread_rhs) ? STATUS_NOISY : STATUS_GOOD;
    endfunction

    function void note_request(logic cmd, logic [CH_W-1:0] ch, logic [ADC_W-1:0] adc,
                               logic [ADC_W-1:0] th);
      logic              in_range;
      logic [CNT_BITS:0] next_count;
      logic [SUM_W:0]    next_sum;
      logic [SQ_W:0]     next_square;
      report_t           rep;
      in_range = (int'(ch) < NUM_CH);
      if (cmd == CMD_REPORT) begin
        rep.channel = ch;
        rep.total   = in_range ? hit_count[ch] : '0;
        rep.sum     = in_range ? adc_total[ch] : '0;
        rep.square  = in_range ? square_total[ch] : '0;
        rep.status  = grade_channel(rep.total, rep.sum, rep.square);
        pending_reports.push_back(rep);
        return;
      end
      if (!in_range || th == TH_OFF_LO || th == TH_OFF_HI) return;
      if (9'(adc) + 9'(shift) <= 9'(th)) return;
      next_count  = {1'b0, hit_count[ch]} + 1'b1;
      next_sum    = {1'b0, adc_total[ch]} + (SUM_W+1)'(adc);
      next_square = {1'b0, square_total[ch]} + (SQ_W+1)'(adc) * (SQ_W+1)'(adc);
      // a hit that would overflow any field is dropped, the channel stays as it was
      if (next_count[CNT_BITS] || next_sum[SUM_W] || next_square[SQ_W]) return;
      hit_count[ch]    = next_count[CNT_BITS-1:0];
      adc_total[ch]    = next_sum[SUM_W-1:0];
      square_total[ch] = next_square[SQ_W-1:0];
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $error("report for channel %0d with no request waiting", got.channel);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("out_channel", 64'(want.channel), 64'(got.channel));
      compare_field("hit_total", 64'(want.total), 64'(got.total));
      compare_field("adc_sum", 64'(want.sum), 64'(got.sum));
      compare_field("adc_square_sum", 64'(want.square), 64'(got.square));
      compare_field("status", 64'(want.status), 64'(got.status));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic               pready;

  chdc_in_if                              in_req ();
  chdc_out_if #(.COUNT_BITS(CNT_BITS))    out_req ();

  channel_hot_dead_classifier_unit #(
    .NUM_CHANNELS(NUM_CH),
    .COUNT_BITS  (CNT_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_req(out_req),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  channel_stats_board board;

  // idle percentages of both sides, switched per phase by the main sequence
  int send_idle_pct = 33;
  int recv_idle_pct = 87;
  // long receiver hold-off: the main sequence bumps hold_reqs, the receiver
  // notices the change and counts the hold itself
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side ready: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_req.ready <= 1'b0;
    end else begin
      out_req.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // every accepted report result is checked against the oldest expectation
  always @(posedge clk) begin
    report_t seen;
    if (rst_n && out_req.valid && out_req.ready) begin
      seen.channel = out_req.out_channel;
      seen.total   = out_req.hit_total;
      seen.sum     = out_req.adc_sum;
      seen.square  = out_req.adc_square_sum;
      seen.status  = out_req.status;
      board.check_report(seen);
    end
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_req.valid && out_req.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one request at a falling edge, hold it until accepted
  task automatic send_request(logic cmd, logic [CH_W-1:0] ch, logic [ADC_W-1:0] adc,
                              logic [ADC_W-1:0] th);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.command   <= cmd;
    in_req.channel   <= ch;
    in_req.adc       <= adc;
    in_req.threshold <= th;
    do @(posedge clk); while (!in_req.ready);
    board.note_request(cmd, ch, adc, th);
    @(negedge clk);
  endtask

  // stop offering, wait for every owed report, then let a hit write-back finish
  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
    @(negedge clk);
  endtask

  // one apb transfer: setup cycle, then access cycle until pready
  task automatic apb_access(logic write, logic [1:0] idx, logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write with junk in the upper bits, then read back the 8-bit value
  task automatic write_register(logic [1:0] idx, logic [CFG_W-1:0] value);
    logic [PDATA_W-1:0] wdata, readback;
    wdata = $urandom;
    wdata[CFG_W-1:0] = value;
    apb_access(1'b1, idx, wdata, readback);
    board.set_register(idx, value);
    apb_access(1'b0, idx, '0, readback);
    if (readback !== PDATA_W'(board.register_value(idx))) begin
      $error("register %0d: expected %0d, got %0d", idx, value, readback);
      board.errors++;
    end
  endtask

  task automatic apply_limits(logic [CFG_W-1:0] shift, logic [CFG_W-1:0] dead,
                              logic [CFG_W-1:0] hot, logic [CFG_W-1:0] rms);
    write_register(REG_SHIFT, shift);
    write_register(REG_DEAD, dead);
    write_register(REG_HOT, hot);
    write_register(REG_RMS, rms);
  endtask

  // random traffic on a small pool of channels, each with its own adc profile,
  // mixed with reports and stray hits on any channel
  task automatic run_phase(int items, int pause_at);
    logic [CH_W-1:0]  pool [8];
    logic [ADC_W-1:0] center [8];
    int               spread [8];
    bit               bimodal [8];
    int               k, pick, level;
    logic [ADC_W-1:0] adc, th;
    foreach (pool[i]) begin
      pool[i]    = (i == 0) ? '0 : (i == 1) ? '1 : CH_W'($urandom);
      bimodal[i] = 1'b0;
      case ($urandom_range(3))
        0: center[i] = ADC_W'($urandom_range(0, 12));
        1: center[i] = ADC_W'($urandom_range(190, 255));
        2: bimodal[i] = 1'b1;
        default: center[i] = ADC_W'($urandom);
      endcase
      spread[i] = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 60);
    end
    for (k = 0; k < items; k++) begin
      if (k == pause_at) wait_drained();
      pick = $urandom_range(7);
      if ($urandom_range(99) < 12) begin
        // mostly pool channels, sometimes an arbitrary (usually empty) one
        send_request(CMD_REPORT, ($urandom_range(9) == 0) ? CH_W'($urandom) : pool[pick],
                     ADC_W'($urandom), ADC_W'($urandom));
      end else if ($urandom_range(99) < 8) begin
        send_request(CMD_HIT, CH_W'($urandom), ADC_W'($urandom), ADC_W'($urandom));
      end else begin
        if (bimodal[pick]) begin
          level = $urandom_range(1) ? $urandom_range(0, 30) : $urandom_range(225, 255);
        end else begin
          level = int'(center[pick]) + int'($urandom_range(0, 2 * spread[pick]))
                  - spread[pick];
        end
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        adc = ADC_W'(level);
        // threshold mostly low, with the disable codes and the edge near adc
        case ($urandom_range(9))
          0: th = $urandom_range(1) ? TH_OFF_LO : TH_OFF_HI;
          1: th = ADC_W'($urandom);
          2: th = adc;
          3: th = adc - 8'd1;
          default: th = ADC_W'($urandom_range(1, 20));
        endcase
        send_request(CMD_HIT, pool[pick], adc, th);
      end
    end
  endtask

  initial begin
    int p, n;
    board = new();
    in_req.valid     = 1'b0;
    in_req.command   = CMD_HIT;
    in_req.channel   = '0;
    in_req.adc       = '0;
    in_req.threshold = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset limits
    send_request(CMD_REPORT, '0, 8'd0, 8'd0);     // empty channel reads dead
    send_request(CMD_REPORT, '1, 8'd255, 8'd255);
    send_request(CMD_HIT, '0, 8'd255, TH_OFF_LO); // disabled threshold codes
    send_request(CMD_HIT, '0, 8'd255, TH_OFF_HI);
    send_request(CMD_HIT, '0, 8'd0, 8'd1);        // below threshold
    send_request(CMD_HIT, '0, 8'd77, 8'd77);      // equal is not above
    send_request(CMD_HIT, '0, 8'd78, 8'd77);      // just above
    send_request(CMD_REPORT, '0, 8'd0, 8'd0);
    for (n = 0; n < 4; n++) send_request(CMD_HIT, '1, 8'd255, 8'd254);
    send_request(CMD_REPORT, '1, 8'd0, 8'd0);     // hot
    for (n = 0; n < 3; n++) send_request(CMD_HIT, 12'd1, 8'd5, 8'd4);
    send_request(CMD_REPORT, 12'd1, 8'd0, 8'd0);  // dead by low mean
    for (n = 0; n < 4; n++) send_request(CMD_HIT, 12'd2, n[0] ? 8'd240 : 8'd20, 8'd10);
    send_request(CMD_REPORT, 12'd2, 8'd0, 8'd0);  // wide spread, noisy
    for (n = 0; n < 2; n++) send_request(CMD_HIT, 12'd3, 8'd100, 8'd1);
    send_request(CMD_REPORT, 12'd3, 8'd0, 8'd0);  // zero spread, good
    wait_drained();

    // random phases: limits change between phases, idling pattern every two
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_limits(SHIFT_RST, DEAD_RST, HOT_RST, RMS_RST);
        1: apply_limits(8'd255, 8'd0, 8'd255, 8'd0);
        2: apply_limits(8'd0, 8'd255, 8'd0, 8'd255);
        4: apply_limits(8'd40, 8'd60, 8'd120, 8'd40);
        default: apply_limits(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                              CFG_W'($urandom));
      endcase
      case (p / 2)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // full-rate phase with a long result stall so the input backs up
      if (p == 4) hold_reqs++;
      // one phase pauses midway until all reports are back
      run_phase(PHASE_ITEMS, (p == 2) ? PHASE_ITEMS / 2 : -1);
      wait_drained();
    end

    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/chdc_pkg.sv
rtl/core/chdc_in_if.sv
rtl/core/chdc_out_if.sv
rtl/core/chdc_ram.sv
rtl/core/chdc_fifo.sv
rtl/core/chdc_front.sv
rtl/core/chdc_classify.sv
rtl/core/chdc_back.sv
rtl/core/channel_hot_dead_classifier_unit.sv
verif/tb.sv
